/* hw/rtl/wifd_pkg.sv */
package wifd_pkg;

  localparam int unsigned MaxFieldBytes = 10;
  localparam int unsigned SignWidth     = 2;
  localparam int unsigned WordWidth     = 4;
  localparam int unsigned Int8Width     = 10;

  localparam int unsigned CountWidth = 4;
  localparam int unsigned StoreWidth = 8 * MaxFieldBytes;

  localparam logic [CountWidth-1:0] MaxCount  = CountWidth'(MaxFieldBytes);
  localparam logic [CountWidth-1:0] OverCount = CountWidth'(MaxFieldBytes + 1);

  localparam logic [2:0] KIND_INT2 = 3'd0;
  localparam logic [2:0] KIND_INT4 = 3'd1;
  localparam logic [2:0] KIND_INT8 = 3'd2;
  localparam logic [2:0] KIND_SM10 = 3'd3;
  localparam logic [2:0] KIND_BOOL = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_PROTO = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [15:0] SIGN_POS = 16'h0001;
  localparam logic [15:0] SIGN_NEG = 16'hFFFF;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // take the byte on the input ports
    logic close;    // the captured byte ends the value: hold its kind
    logic finish;   // decode the stored value and present the result
  } wifd_cmd_t;

endpackage

/* hw/rtl/wifd_ctrl.sv */
module wifd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               last_byte_i,
  output logic               busy_o,
  output wifd_pkg::wifd_cmd_t cmd_o
);

  wifd_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wifd_pkg::ST_IDLE: begin
        if (start_i && last_byte_i) begin
          state_d = wifd_pkg::ST_DECODE;
        end
      end
      wifd_pkg::ST_DECODE: begin
        state_d = wifd_pkg::ST_IDLE;
      end
      default: begin
        state_d = wifd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o         = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.close    = 1'b0;
    cmd_o.finish   = 1'b0;
    unique case (state_q)
      wifd_pkg::ST_IDLE: begin
        cmd_o.capture = start_i;
        cmd_o.close   = start_i && last_byte_i;
      end
      wifd_pkg::ST_DECODE: begin
        busy_o       = 1'b1;
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wifd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/wifd_datapath.sv */
module wifd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wifd_pkg::wifd_cmd_t cmd_i,
  input  logic [7:0]          data_byte_i,
  input  logic [2:0]          column_kind_i,
  output logic signed [63:0]  value_o,
  output logic [1:0]          status_o,
  output logic                done_o
);

  // Bytes of the value in wire order, newest in the low byte
  logic [wifd_pkg::StoreWidth-1:0] store_q, store_d;
  logic [wifd_pkg::CountWidth-1:0] count_q, count_d;
  logic [2:0]                      kind_q;
  logic [63:0]                     value_q, value_d;
  logic [1:0]                      status_q, status_d;
  logic                            done_q;

  logic [15:0] sign_word;
  logic [63:0] mag;
  logic        neg;
  logic        mag_over;
  logic [7:0]  first_byte;

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    if (cmd_i.finish) begin
      count_d = '0;
    end else if (cmd_i.capture) begin
      if (count_q < wifd_pkg::MaxCount) begin
        store_d = {store_q[wifd_pkg::StoreWidth-9:0], data_byte_i};
        count_d = count_q + 1'b1;
      end else begin
        // drop the byte and saturate the count
        count_d = wifd_pkg::OverCount;
      end
    end
  end

  assign sign_word  = store_q[79:64];
  // low magnitude word comes first on the wire, high word last
  assign mag        = {store_q[31:0], store_q[63:32]};
  assign neg        = (sign_word == wifd_pkg::SIGN_NEG);
  // beyond 2^63 - 1, except exactly 2^63 for a negative value
  assign mag_over   = mag[63] && (!neg || (mag[62:0] != '0));
  assign first_byte = store_q[7:0];

  always_comb begin
    value_d  = '0;
    status_d = wifd_pkg::STATUS_PROTO;
    unique case (kind_q)
      wifd_pkg::KIND_INT2: begin
        if (count_q == wifd_pkg::CountWidth'(2)) begin
          value_d  = {{48{store_q[15]}}, store_q[15:0]};
          status_d = wifd_pkg::STATUS_OK;
        end
      end
      wifd_pkg::KIND_INT4: begin
        if (count_q == wifd_pkg::CountWidth'(4)) begin
          value_d  = {{32{store_q[31]}}, store_q[31:0]};
          status_d = wifd_pkg::STATUS_OK;
        end
      end
      wifd_pkg::KIND_INT8: begin
        if (count_q == wifd_pkg::CountWidth'(8)) begin
          value_d  = store_q[63:0];
          status_d = wifd_pkg::STATUS_OK;
        end
      end
      wifd_pkg::KIND_SM10: begin
        if (count_q == wifd_pkg::CountWidth'(wifd_pkg::Int8Width) &&
            (sign_word == wifd_pkg::SIGN_POS || neg)) begin
          if (mag_over) begin
            status_d = wifd_pkg::STATUS_RANGE;
          end else begin
            value_d  = neg ? (64'd0 - mag) : mag;
            status_d = wifd_pkg::STATUS_OK;
          end
        end
      end
      wifd_pkg::KIND_BOOL: begin
        if (count_q == wifd_pkg::CountWidth'(1)) begin
          case (first_byte) inside
            8'h00, "0", "f", "F", "n", "N": begin
              value_d  = 64'd0;
              status_d = wifd_pkg::STATUS_OK;
            end
            8'h01, 8'hFF, "1", "t", "T", "y", "Y": begin
              value_d  = 64'd1;
              status_d = wifd_pkg::STATUS_OK;
            end
            default: begin
              status_d = wifd_pkg::STATUS_PROTO;
            end
          endcase
        end
      end
      default: begin
        status_d = wifd_pkg::STATUS_PROTO;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.close) begin
      kind_q <= column_kind_i;
    end
    if (cmd_i.finish) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;
  assign done_o   = done_q;

endmodule

/* hw/rtl/wire_integer_field_decoder_core.sv */
// Bytes that do not end a value are taken one per cycle, busy_o stays low.
// The marked last byte holds busy_o high for one decode cycle; the result
// appears with done_o in the cycle after that.
// No byte is taken in the decode cycle, which sets the gap between values.
// Reset clears the byte count and the controller; done_o is low after reset.
module wire_integer_field_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         data_byte_i,
  input  logic [2:0]         column_kind_i,
  input  logic               last_byte_i,
  output logic               done_o,
  output logic signed [63:0] value_o,
  output logic [1:0]         status_o
);

  wifd_pkg::wifd_cmd_t cmd;

  wifd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_byte_i (last_byte_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd)
  );

  wifd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .column_kind_i (column_kind_i),
    .value_o       (value_o),
    .status_o      (status_o),
    .done_o        (done_o)
  );

endmodule
